// ===== hw/rtl/lpct_pkg.sv =====
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants of the linear probing key count table.
// ----------------------------------------------------------------------------
package lpct_pkg;

    localparam int ADDR_W      = 10;
    localparam int TABLE_SIZE  = 1 << ADDR_W;
    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int ENTRY_W     = KEY_W + COUNT_W;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - ADDR_W - COUNT_W;
    localparam int STATUS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_ZERO     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_WAIT
    } state_t;

endpackage

// ===== hw/rtl/lpct_ram.sv =====
// ----------------------------------------------------------------------------
// lpct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpct_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/linear_probe_count_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_count_table
// Counts occurrences of 32-bit keys in a linear probing hash table.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry key/count memory to zero, one
// entry a cycle, with s_tready low until the sweep is done. Each key is then
// taken in ST_IDLE and probed from its home slot (key modulo 1024),
// one slot a cycle through the single read port of the table memory, up to
// 1024 slots in all; a zero key is answered without a probe. The result sits
// in an output register, and a new key is taken while it waits; a result that
// finds that register still full is held in ST_WAIT, where no key is taken.
module linear_probe_count_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot[9:0], count[41:10], zero pad[47:42]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = lpct_pkg::ADDR_W;
    localparam int KW = lpct_pkg::KEY_W;
    localparam int CW = lpct_pkg::COUNT_W;
    localparam logic [AW-1:0] ADDR_MAX = {AW{1'b1}};

    lpct_pkg::state_t state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] probe_cnt_reg, probe_cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [KW-1:0] key_reg, key_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [AW-1:0]         out_slot_reg, out_slot_next;
    logic [CW-1:0]         out_count_reg, out_count_next;
    lpct_pkg::status_t     out_status_reg, out_status_next;
    logic [AW-1:0]         pend_slot_reg, pend_slot_next;
    logic [CW-1:0]         pend_count_reg, pend_count_next;
    lpct_pkg::status_t     pend_status_reg, pend_status_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [lpct_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [lpct_pkg::ENTRY_W-1:0] ram_rdata;

    logic [KW-1:0]     held_key;
    logic [CW-1:0]     held_count;
    logic [CW-1:0]     sat_count;
    logic              out_free;
    logic              fin;
    logic [AW-1:0]     fin_slot;
    logic [CW-1:0]     fin_count;
    lpct_pkg::status_t fin_status;

    lpct_ram #(
        .WIDTH (lpct_pkg::ENTRY_W),
        .DEPTH (lpct_pkg::TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign held_key   = ram_rdata[KW-1:0];
    assign held_count = ram_rdata[KW +: CW];
    assign sat_count  = (held_count == {CW{1'b1}}) ? held_count : held_count + 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        probe_cnt_next   = probe_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        key_next         = key_reg;
        pend_slot_next   = pend_slot_reg;
        pend_count_next  = pend_count_reg;
        pend_status_next = pend_status_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        m_tvalid_next    = m_tready ? 1'b0 : m_tvalid_reg;
        ram_we           = 1'b0;
        ram_waddr        = pos_reg;
        ram_wdata        = '0;
        ram_raddr        = pos_reg;
        fin              = 1'b0;
        fin_slot         = '0;
        fin_count        = '0;
        fin_status       = lpct_pkg::STATUS_ZERO;

        case (state_reg)
            lpct_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == ADDR_MAX)
                begin
                    state_next = lpct_pkg::ST_IDLE;
                end
            end
            lpct_pkg::ST_IDLE:
            begin
                ram_raddr = s_tdata[AW-1:0];
                if (s_tvalid)
                begin
                    if (s_tdata == '0)
                    begin
                        fin        = 1'b1;
                        fin_status = lpct_pkg::STATUS_ZERO;
                    end
                    else
                    begin
                        key_next       = s_tdata;
                        pos_next       = s_tdata[AW-1:0];
                        probe_cnt_next = '0;
                        state_next     = lpct_pkg::ST_PROBE;
                    end
                end
            end
            lpct_pkg::ST_PROBE:
            begin
                if (held_key == key_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {sat_count, key_reg};
                    fin        = 1'b1;
                    fin_slot   = pos_reg;
                    fin_count  = sat_count;
                    fin_status = lpct_pkg::STATUS_FOUND;
                end
                else if (held_key == '0)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {CW'(1), key_reg};
                    fin        = 1'b1;
                    fin_slot   = pos_reg;
                    fin_count  = CW'(1);
                    fin_status = lpct_pkg::STATUS_INSERTED;
                end
                else if (probe_cnt_reg == ADDR_MAX)
                begin
                    fin        = 1'b1;
                    fin_status = lpct_pkg::STATUS_FULL;
                end
                else
                begin
                    pos_next       = AW'(pos_reg + 1'b1);
                    probe_cnt_next = AW'(probe_cnt_reg + 1'b1);
                    ram_raddr      = AW'(pos_reg + 1'b1);
                end
            end
            lpct_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    out_slot_next   = pend_slot_reg;
                    out_count_next  = pend_count_reg;
                    out_status_next = pend_status_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = lpct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpct_pkg::ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_slot_next   = fin_slot;
                out_count_next  = fin_count;
                out_status_next = fin_status;
                m_tvalid_next   = 1'b1;
                state_next      = lpct_pkg::ST_IDLE;
            end
            else
            begin
                pend_slot_next   = fin_slot;
                pend_count_next  = fin_count;
                pend_status_next = fin_status;
                state_next       = lpct_pkg::ST_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpct_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        key_reg         <= key_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
        out_status_reg  <= out_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_count_reg  <= pend_count_next;
        pend_status_reg <= pend_status_next;
    end

    assign s_tready = (state_reg == lpct_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{lpct_pkg::OUT_PAD_W{1'b0}}, out_count_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== hw/rtl/lpct_checker.sv =====
// ----------------------------------------------------------------------------
// lpct_checker
// Port-level checks of the key count table, bound to the top level.
// ----------------------------------------------------------------------------
module lpct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a nonzero key always takes the block out of idle to probe
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata != '0) |=> !s_tready)
    else $error("ready held after nonzero key transaction");

    // zero key is answered in the next cycle when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata == '0) && (!m_tvalid || m_tready)
        |=> m_tvalid && (m_tuser == lpct_pkg::STATUS_ZERO) && (m_tdata == '0))
    else $error("zero key result wrong");

    // fresh insert always reports a count of one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lpct_pkg::STATUS_INSERTED) |-> (m_tdata[41:10] == 32'd1))
    else $error("insert count not one");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind linear_probe_count_table lpct_checker u_lpct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/linear_probe_count_table_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_count_table_tb
// Drives key streams into the linear probing count table and checks every
// result (slot, count, status) against a behavioral copy of the table held
// here. Covers zero keys, home slot collisions, wrap at the table end, long
// probe clusters, output back-pressure, a completely filled table and keys
// that find no room in it.
// ----------------------------------------------------------------------------
module linear_probe_count_table_tb;

    localparam int CLK_PERIOD = 8;
    localparam int RUN_LIMIT  = 600000;
    localparam int RAND_ITEMS = 750;
    localparam int DRAIN_WAIT = 1100;

    typedef struct packed {
        logic [lpct_pkg::ADDR_W-1:0]  slot;
        logic [lpct_pkg::COUNT_W-1:0] count;
        lpct_pkg::status_t            status;
    } count_result_t;

    typedef enum {RX_STEADY, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                         clk      = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [lpct_pkg::KEY_W-1:0]   s_tdata;    // key[31:0]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [47:0]                  m_tdata;    // slot[9:0], count[41:10], zero pad[47:42]
    logic [1:0]                   m_tuser;    // status[1:0]

    logic [lpct_pkg::KEY_W-1:0]   table_keys   [lpct_pkg::TABLE_SIZE];
    logic [lpct_pkg::COUNT_W-1:0] table_counts [lpct_pkg::TABLE_SIZE];
    count_result_t                pending_counts[$];
    logic [lpct_pkg::KEY_W-1:0]   key_pool[$];

    int       error_count   = 0;
    int       cycle_count   = 0;
    bit       pace_on       = 1'b1;
    int       burst_left    = 0;
    int       hold_request  = 0;
    int       hold_left     = 0;
    int       mode_left     = 0;
    int       pattern_phase = 0;
    rx_mode_t rx_mode       = RX_STEADY;
    logic [7:0] stall_pattern = 8'b1011_0110;

    linear_probe_count_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        for (int i = 0; i < lpct_pkg::TABLE_SIZE; i++)
        begin
            table_keys[i]   = '0;
            table_counts[i] = '0;
        end
    end

    // probe from the home slot, update the table copy, give the expected result
    function automatic count_result_t count_key(input logic [lpct_pkg::KEY_W-1:0] key);
        count_result_t res;
        int unsigned   pos;
        res.slot   = '0;
        res.count  = '0;
        res.status = lpct_pkg::STATUS_ZERO;
        if (key == '0)
            return res;
        pos = key % lpct_pkg::TABLE_SIZE;
        for (int n = 0; n < lpct_pkg::TABLE_SIZE; n++)
        begin
            if (table_keys[pos] == key)
            begin
                if (table_counts[pos] != '1)
                    table_counts[pos] = table_counts[pos] + 1'b1;
                res.slot   = pos[lpct_pkg::ADDR_W-1:0];
                res.count  = table_counts[pos];
                res.status = lpct_pkg::STATUS_FOUND;
                return res;
            end
            if (table_keys[pos] == '0)
            begin
                table_keys[pos]   = key;
                table_counts[pos] = 1;
                res.slot   = pos[lpct_pkg::ADDR_W-1:0];
                res.count  = 1;
                res.status = lpct_pkg::STATUS_INSERTED;
                return res;
            end
            pos = (pos + 1) % lpct_pkg::TABLE_SIZE;
        end
        res.status = lpct_pkg::STATUS_FULL;
        return res;
    endfunction

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            pending_counts.push_back(count_key(s_tdata));
    end

    // result checker
    always @(posedge clk)
    begin
        count_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("result transaction with no expected result pending");
                error_count++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (m_tdata[lpct_pkg::ADDR_W-1:0] !== want.slot)
                begin
                    $error("slot expected %0d got %0d", want.slot,
                           m_tdata[lpct_pkg::ADDR_W-1:0]);
                    error_count++;
                end
                if (m_tdata[lpct_pkg::ADDR_W +: lpct_pkg::COUNT_W] !== want.count)
                begin
                    $error("count expected %0d got %0d", want.count,
                           m_tdata[lpct_pkg::ADDR_W +: lpct_pkg::COUNT_W]);
                    error_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0)
        begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
        end
        else
            mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:  m_tready <= 1'b1;
                RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN:
                begin
                    m_tready      <= stall_pattern[pattern_phase % 8];
                    pattern_phase <= pattern_phase + 1;
                end
                default:    m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_key(input logic [lpct_pkg::KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (pace_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    // zero keys, extremes, collisions on home slot zero and wrap from the last slot
    task automatic test_directed_keys();
        logic [lpct_pkg::KEY_W-1:0] keys [16] = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
            32'h0000_0401, 32'h0000_0400, 32'hFFFF_FC00, 32'h0000_07FF,
            32'h0000_07FF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
            32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001
        };
        pace_on = 1'b0;
        foreach (keys[i])
        begin
            send_key(keys[i]);
            if (keys[i] != '0)
                key_pool.push_back(keys[i]);
        end
        pace_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_request = 400;
        pace_on      = 1'b0;
        for (int i = 0; i < 16; i++)
            send_key($urandom_range(1, 40));
        pace_on = 1'b1;
    endtask

    // zero keys, repeats from a pool, fresh keys and keys piled on eight home slots
    task automatic test_random_keys();
        logic [lpct_pkg::ADDR_W-1:0] hot_homes [8] = '{0, 1, 2, 1022, 1023, 512, 513, 700};
        logic [lpct_pkg::KEY_W-1:0]  key;
        int                          pick;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            pace_on = ((i / 150) % 3) != 1;
            pick    = $urandom_range(0, 99);
            if (pick < 5)
                key = '0;
            else if (pick < 35 || key_pool.size() == 0)
            begin
                key = $urandom;
                if ($urandom_range(0, 1) == 1)
                    key[lpct_pkg::ADDR_W-1:0] = hot_homes[$urandom_range(0, 7)];
                if (key != '0)
                    key_pool.push_back(key);
            end
            else
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_key(key);
        end
        pace_on = 1'b1;
        drain_results(0);
    endtask

    // every empty slot gets a key whose home is that slot
    task automatic test_fill_table();
        logic [lpct_pkg::KEY_W-1:0] key;
        for (int s = 0; s < lpct_pkg::TABLE_SIZE; s++)
        begin
            if (table_keys[s] == '0)
            begin
                key                       = $urandom;
                key[lpct_pkg::ADDR_W-1:0] = s[lpct_pkg::ADDR_W-1:0];
                if (key == '0)
                    key[lpct_pkg::KEY_W-1] = 1'b1;
                send_key(key);
            end
        end
        drain_results(0);
    endtask

    task automatic test_full_table();
        logic [lpct_pkg::KEY_W-1:0] key;
        bit                         present;
        send_key('0);
        for (int i = 0; i < 5; i++)
        begin
            do
            begin
                key = $urandom;
                if (i == 0)
                    key[lpct_pkg::ADDR_W-1:0] = '0;
                else if (i == 1)
                    key[lpct_pkg::ADDR_W-1:0] = '1;
                present = (key == '0);
                foreach (table_keys[s])
                    if (table_keys[s] == key)
                        present = 1'b1;
            end
            while (present);
            send_key(key);
        end
        for (int i = 0; i < 24; i++)
            send_key(table_keys[$urandom_range(0, lpct_pkg::TABLE_SIZE - 1)]);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed_keys();
        test_output_backpressure();
        test_random_keys();
        test_fill_table();
        test_full_table();
        drain_results(DRAIN_WAIT);
        if (error_count == 0 && pending_counts.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== linear_probe_count_table.f =====
hw/rtl/lpct_pkg.sv
hw/rtl/lpct_ram.sv
hw/rtl/linear_probe_count_table.sv
hw/rtl/lpct_checker.sv
sim/linear_probe_count_table_tb.sv
